// ===== rtl/bilinear_image_scaler_defines.svh =====
// Assertion macros for the bilinear image scaler checker.
// Included by bis_checker.sv; depends on nothing else.
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH

// Implication that checks the consequent in the clock after the antecedent.
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bilinear scaler: next-cycle check failed");

// Implication that checks the consequent in the same clock as the antecedent.
`define BIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bilinear scaler: same-cycle check failed");

`endif

// ===== rtl/bis_pkg.sv =====
// Shared types, constants and helpers for the bilinear image scaler.
// No dependencies; imported by bis_step_div and bilinear_image_scaler.
`timescale 1ns / 1ps

package bis_pkg;

    // Q.16 step ratio width and fraction width.
    localparam int STEP_W = 26;
    localparam int FRAC_W = 16;
    localparam int SIZE_W = 10;
    localparam logic [STEP_W-1:0] ONE_Q16 = 26'd65536;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } cfg_index_t;

    // Operation codes of a request.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [8:0] column;
        logic [8:0] row;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } bis_req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } bis_rsp_t;

    // Effective size: zero reads as one, values over the limit read as the limit.
    function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                     logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = 10'd1;
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/bilinear_image_scaler.sv =====
// Top level of the RGB888 bilinear image scaler with its source frame store.
// Depends on bis_pkg and bis_step_div.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// A write request (op 0) stores one source pixel in that same edge and the
// block is free again in the next cycle; writes outside the source size are
// dropped. A read request (op 1) yields one interpolated pixel: done pulses
// for one cycle with the result, and no new request is taken until then;
// the block is free again in the same cycle that done is high.
// The four neighbours are read one per cycle through the single frame store
// port, after a position multiply, an edge clamp and a weight stage.
// A configuration write holds busy high while two serial dividers form the
// column and row step ratios, one quotient bit per cycle.
// The receiver cannot stall: done marks each result for exactly one cycle.
// Reset clears the control state and sets the size registers to 504 x 336
// for both frames with ratio one; the frame store holds no defined contents
// until written, and there is no clearing pass.
`timescale 1ns / 1ps

module bilinear_image_scaler
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bis_req_t          request,
    output logic              busy,
    output logic              done,
    output bis_rsp_t          result,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [SIZE_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [SIZE_W-1:0] W_LIM = SIZE_W'((MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH);
    localparam logic [SIZE_W-1:0] H_LIM = SIZE_W'((MAX_HEIGHT > 1023) ? 1023 : MAX_HEIGHT);
    localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(MAX_WIDTH);
    localparam int POS_W = 9 + STEP_W;
    localparam int INT_W = POS_W - FRAC_W;
    localparam int W_W   = 2 * FRAC_W + 1;
    localparam int ACC_W = W_W + 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_CLAMP,
        ST_WGT,
        ST_READ,
        ST_LAST
    } state_t;

    // Configuration and step ratios.
    logic [SIZE_W-1:0] src_width_reg;
    logic [SIZE_W-1:0] src_height_reg;
    logic [SIZE_W-1:0] dst_width_reg;
    logic [SIZE_W-1:0] dst_height_reg;
    logic              cfg_pend_reg;
    logic [SIZE_W-1:0] sw_eff;
    logic [SIZE_W-1:0] sh_eff;
    logic [SIZE_W-1:0] dw_eff;
    logic [SIZE_W-1:0] dh_eff;
    logic [SIZE_W-1:0] sw_m1;
    logic [SIZE_W-1:0] sh_m1;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
    logic              div_x_busy;
    logic              div_y_busy;

    // Sequencer state and datapath registers.
    state_t            state_reg;
    logic [8:0]        col_reg;
    logic [8:0]        row_reg;
    logic [POS_W-1:0]  px_reg;
    logic [POS_W-1:0]  py_reg;
    logic [SIZE_W-1:0] x0_reg;
    logic [SIZE_W-1:0] x1_reg;
    logic [SIZE_W-1:0] y0_reg;
    logic [SIZE_W-1:0] y1_reg;
    logic [FRAC_W-1:0] fx_reg;
    logic [FRAC_W-1:0] fy_reg;
    logic [W_W-1:0]    w_reg [4];
    logic [ADDR_W-1:0] row0_reg;
    logic [ADDR_W-1:0] row1_reg;
    logic [1:0]        rd_cnt_reg;
    logic [1:0]        tap_reg;
    logic              tap_valid_reg;
    logic [ACC_W-1:0]  acc_reg [3];
    logic              done_reg;
    bis_rsp_t          result_reg;

    // Frame store.
    logic [23:0]       frame_mem [DEPTH];
    logic [23:0]       rd_data_reg;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] mem_addr;

    // Combinational helpers.
    logic              accept;
    logic [INT_W-1:0]  ix;
    logic [INT_W-1:0]  iy;
    logic [SIZE_W-1:0] x0_c;
    logic [SIZE_W-1:0] y0_c;
    logic [SIZE_W-1:0] x1_c;
    logic [SIZE_W-1:0] y1_c;
    logic [FRAC_W:0]   nfx;
    logic [FRAC_W:0]   nfy;
    logic [ACC_W-1:0]  acc_sum [3];
    bis_rsp_t          sat_rsp;

    // Effective sizes seen by the range check, the clamps and the dividers.
    assign sw_eff = clamp_size(src_width_reg, W_LIM);
    assign sh_eff = clamp_size(src_height_reg, H_LIM);
    assign dw_eff = clamp_size(dst_width_reg, W_LIM);
    assign dh_eff = clamp_size(dst_height_reg, H_LIM);
    assign sw_m1  = sw_eff - 1'b1;
    assign sh_m1  = sh_eff - 1'b1;

    // The block stays busy while a read runs or a step ratio is recomputed.
    assign busy   = (state_reg != ST_IDLE) || cfg_write || cfg_pend_reg
                    || div_x_busy || div_y_busy;
    assign accept = start && !busy;

    // Configuration registers; the dividers start in the cycle after a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 10'd504;
            src_height_reg <= 10'd336;
            dst_width_reg  <= 10'd504;
            dst_height_reg <= 10'd336;
            cfg_pend_reg   <= 1'b0;
        end
        else
        begin
            cfg_pend_reg <= cfg_write;
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                    CFG_SRC_HEIGHT: src_height_reg <= cfg_data;
                    CFG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                    CFG_DST_HEIGHT: dst_height_reg <= cfg_data;
                    default:        src_width_reg  <= src_width_reg;
                endcase
            end
        end
    end

    bis_step_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_pend_reg),
        .num   (sw_eff),
        .den   (dw_eff),
        .busy  (div_x_busy),
        .step  (x_step)
    );

    bis_step_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_pend_reg),
        .num   (sh_eff),
        .den   (dh_eff),
        .busy  (div_y_busy),
        .step  (y_step)
    );

    // Source pixel writes land in the store at the accepting edge.
    assign wr_en   = accept && (request.op == OP_WRITE)
                     && ({1'b0, request.column} < sw_eff)
                     && ({1'b0, request.row} < sh_eff);
    assign wr_addr = ADDR_W'(request.row) * ROW_PITCH + ADDR_W'(request.column);

    // Neighbour read address, one corner per cycle.
    always_comb
    begin
        case (rd_cnt_reg)
            2'd0:    rd_addr = row0_reg + ADDR_W'(x0_reg);
            2'd1:    rd_addr = row0_reg + ADDR_W'(x1_reg);
            2'd2:    rd_addr = row1_reg + ADDR_W'(x0_reg);
            2'd3:    rd_addr = row1_reg + ADDR_W'(x1_reg);
            default: rd_addr = row0_reg;
        endcase
    end

    assign rd_en    = (state_reg == ST_READ);
    assign mem_addr = wr_en ? wr_addr : rd_addr;

    // Single-port frame store with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[mem_addr] <= {request.red_in, request.green_in, request.blue_in};
        end
        else if (rd_en)
        begin
            rd_data_reg <= frame_mem[mem_addr];
        end
    end

    // Edge clamp of both neighbours and the complementary fractions.
    always_comb
    begin
        ix = px_reg[POS_W-1:FRAC_W];
        iy = py_reg[POS_W-1:FRAC_W];
        if (ix > INT_W'(sw_m1))
        begin
            x0_c = sw_m1;
        end
        else
        begin
            x0_c = ix[SIZE_W-1:0];
        end
        if (iy > INT_W'(sh_m1))
        begin
            y0_c = sh_m1;
        end
        else
        begin
            y0_c = iy[SIZE_W-1:0];
        end
        x1_c = (x0_c >= sw_m1) ? sw_m1 : x0_c + 1'b1;
        y1_c = (y0_c >= sh_m1) ? sh_m1 : y0_c + 1'b1;
        nfx  = (FRAC_W + 1)'(17'h10000 - {1'b0, fx_reg});
        nfy  = (FRAC_W + 1)'(17'h10000 - {1'b0, fy_reg});
    end

    // Weighted accumulation of the pixel that just came out of the store, saturated to eight bits.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc_sum[c] = acc_reg[c]
                         + ACC_W'(rd_data_reg[23 - 8 * c -: 8]) * ACC_W'(w_reg[tap_reg]);
        end
        sat_rsp.red   = (acc_sum[0][ACC_W-1:2*FRAC_W] > 9'd255) ? 8'd255
                        : acc_sum[0][2*FRAC_W+7:2*FRAC_W];
        sat_rsp.green = (acc_sum[1][ACC_W-1:2*FRAC_W] > 9'd255) ? 8'd255
                        : acc_sum[1][2*FRAC_W+7:2*FRAC_W];
        sat_rsp.blue  = (acc_sum[2][ACC_W-1:2*FRAC_W] > 9'd255) ? 8'd255
                        : acc_sum[2][2*FRAC_W+7:2*FRAC_W];
    end

    // Read sequencer: position, clamp, weights, four reads, final sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            tap_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (request.op == OP_READ))
                    begin
                        col_reg   <= request.column;
                        row_reg   <= request.row;
                        state_reg <= ST_POS;
                    end
                end
                ST_POS:
                begin
                    px_reg    <= POS_W'(col_reg) * POS_W'(x_step);
                    py_reg    <= POS_W'(row_reg) * POS_W'(y_step);
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP:
                begin
                    x0_reg    <= x0_c;
                    x1_reg    <= x1_c;
                    y0_reg    <= y0_c;
                    y1_reg    <= y1_c;
                    fx_reg    <= px_reg[FRAC_W-1:0];
                    fy_reg    <= py_reg[FRAC_W-1:0];
                    state_reg <= ST_WGT;
                end
                ST_WGT:
                begin
                    w_reg[0]      <= W_W'(nfx) * W_W'(nfy);
                    w_reg[1]      <= W_W'(fx_reg) * W_W'(nfy);
                    w_reg[2]      <= W_W'(nfx) * W_W'(fy_reg);
                    w_reg[3]      <= W_W'(fx_reg) * W_W'(fy_reg);
                    row0_reg      <= ADDR_W'(y0_reg) * ROW_PITCH;
                    row1_reg      <= ADDR_W'(y1_reg) * ROW_PITCH;
                    for (int c = 0; c < 3; c++)
                    begin
                        acc_reg[c] <= '0;
                    end
                    rd_cnt_reg    <= '0;
                    tap_valid_reg <= 1'b0;
                    state_reg     <= ST_READ;
                end
                ST_READ:
                begin
                    if (tap_valid_reg)
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            acc_reg[c] <= acc_sum[c];
                        end
                    end
                    tap_reg       <= rd_cnt_reg;
                    tap_valid_reg <= 1'b1;
                    rd_cnt_reg    <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == 2'd3)
                    begin
                        state_reg <= ST_LAST;
                    end
                end
                ST_LAST:
                begin
                    result_reg    <= sat_rsp;
                    done_reg      <= 1'b1;
                    tap_valid_reg <= 1'b0;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/bis_step_div.sv =====
// Serial restoring divider that forms one Q.16 step ratio, size * 65536 / size.
// Depends on bis_pkg for the step and size widths.
`timescale 1ns / 1ps

module bis_step_div
    import bis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SIZE_W-1:0] num,
    input  logic [SIZE_W-1:0] den,
    output logic              busy,
    output logic [STEP_W-1:0] step
);

    localparam int CNT_W = $clog2(STEP_W);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [STEP_W-1:0] q_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] den_reg;
    logic [SIZE_W:0]   trial;
    logic              q_bit;
    logic [SIZE_W-1:0] rem_next;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        trial = {rem_reg, q_reg[STEP_W-1]};
        if (trial >= {1'b0, den_reg}) begin
            q_bit    = 1'b1;
            rem_next = SIZE_W'(trial - {1'b0, den_reg});
        end else begin
            q_bit    = 1'b0;
            rem_next = trial[SIZE_W-1:0];
        end
    end

    // The quotient register holds the dividend while it runs and the ratio after.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= ONE_Q16;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            q_reg    <= {num, {FRAC_W{1'b0}}};
        end else if (busy_reg) begin
            q_reg <= {q_reg[STEP_W-2:0], q_bit};
            if (cnt_reg == CNT_W'(STEP_W - 1)) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Remainder and divisor are datapath only.
    always_ff @(posedge clk)
    begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign step = q_reg;

endmodule

// ===== rtl/bis_checker.sv =====
// Port-level checker for the bilinear image scaler, bound to its top level.
// Depends on bilinear_image_scaler_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`include "bilinear_image_scaler_defines.svh"

module bis_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic req_op,
    input logic done,
    input logic cfg_write
);

    // A result strobe lasts a single cycle.
    `BIS_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)

    // An accepted read request occupies the block in the next cycle.
    `BIS_ASSERT_NEXT(a_read_busy, clk, rst_n, start && !busy && req_op, busy)

    // A write request never produces a result.
    `BIS_ASSERT_NEXT(a_write_silent, clk, rst_n, start && !busy && !req_op, !done)

    // A result only follows a cycle in which the block was working.
    `BIS_ASSERT_NOW(a_done_after_busy, clk, rst_n, done, $past(busy))

    // A configuration write blocks requests in the next cycle while steps update.
    `BIS_ASSERT_NEXT(a_cfg_busy, clk, rst_n, cfg_write, busy)

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req_op    (request.op),
    .done      (done),
    .cfg_write (cfg_write)
);
